FILE: rtl/bilinear_image_scaler_unit_defines.svh
// Assertion macros for the bilinear image scaler checker.
// Depends on nothing; the including module must provide clock and reset.
`ifndef BILINEAR_IMAGE_SCALER_UNIT_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_UNIT_DEFINES_SVH

// Check a consequence in the cycle after reset is applied
`define BISC_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

// Check a consequence in the same cycle, outside reset
`define BISC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> (cons)) else $error(msg);

// Check a consequence in the next cycle, outside reset
`define BISC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bisc_pkg.sv
// Shared constants, types and the blend function of the image scaler.
// Used by every module of the block; depends on nothing.
package bisc_pkg;

   // Store geometry and arithmetic format
   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int PIXEL_BITS     = 8;
   localparam int FRAC_BITS      = 16;

   localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int COL_BITS    = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_SRC_HEIGHT);
   localparam int DIM_W_BITS  = $clog2(MAX_SRC_WIDTH + 1);
   localparam int DIM_H_BITS  = $clog2(MAX_SRC_HEIGHT + 1);

   // Port field widths
   localparam int SIZE_BITS      = 9;
   localparam int STEP_BITS      = 24;
   localparam int SRC_COORD_BITS = 8;
   localparam int IN_PIX_BITS    = 8;
   localparam int OUT_COORD_BITS = 12;
   localparam int OUT_PIX_BITS   = 8;
   localparam int CSR_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 3;

   // Source position: coordinate times step
   localparam int POS_BITS = OUT_COORD_BITS + STEP_BITS;
   localparam int INT_BITS = POS_BITS - FRAC_BITS;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COL_STEP    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_STEP    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERP_MODE = 3'd4;

   // Register reset values
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 9'd256;
   localparam logic [STEP_BITS-1:0] STEP_RESET = 24'd65536;

   // Request kinds on the port
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Interpolation modes
   localparam logic MODE_NEAREST  = 1'b0;
   localparam logic MODE_BILINEAR = 1'b1;

   // Command queue and result queue sizes
   localparam int CMD_DEPTH    = 4;
   localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);
   localparam int OUT_DEPTH    = 4;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

   typedef logic [1:0] op_type;

   // Operations handed from front to back
   localparam op_type OP_WRITE   = 2'd0;
   localparam op_type OP_NEAREST = 2'd1;
   localparam op_type OP_BLEND   = 2'd2;

   typedef struct packed {
      op_type                  op;
      logic [COL_BITS-1:0]     x0;
      logic [COL_BITS-1:0]     x1;
      logic [ROW_BITS-1:0]     y0;
      logic [ROW_BITS-1:0]     y1;
      logic [FRAC_BITS-1:0]    fx;
      logic [FRAC_BITS-1:0]    fy;
      logic [PIXEL_BITS-1:0]   pixel;
   } cmd_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] src_width;
      logic [SIZE_BITS-1:0] src_height;
      logic [STEP_BITS-1:0] col_step;
      logic [STEP_BITS-1:0] row_step;
      logic                 interp_mode;
   } cfg_type;

   typedef struct packed {
      logic                    empty;
      logic [CMD_CNT_BITS-1:0] count;
   } qstat_type;

   // One linear step: a + floor((b - a) * f / 2^F), equal to the
   // truncated weighted sum of a and b
   function automatic logic [PIXEL_BITS-1:0] lerp(
      input logic [PIXEL_BITS-1:0] a,
      input logic [PIXEL_BITS-1:0] b,
      input logic [FRAC_BITS-1:0]  f
   );
      logic signed [PIXEL_BITS:0]           diff;
      logic signed [PIXEL_BITS+FRAC_BITS+1:0] prod;
      logic signed [PIXEL_BITS+FRAC_BITS+1:0] shifted;
      diff    = $signed({1'b0, b}) - $signed({1'b0, a});
      prod    = diff * $signed({1'b0, f});
      shifted = prod >>> FRAC_BITS;
      return a + shifted[PIXEL_BITS-1:0];
   endfunction

endpackage

FILE: rtl/bisc_front.sv
// Front end: registers requests, forms source positions and neighbours,
// and classifies each request into a command. Depends on bisc_pkg.
module bisc_front import bisc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_type,
   input  logic [SRC_COORD_BITS-1:0] req_src_col,
   input  logic [SRC_COORD_BITS-1:0] req_src_row,
   input  logic [IN_PIX_BITS-1:0]    req_pixel_in,
   input  logic [OUT_COORD_BITS-1:0] req_out_col,
   input  logic [OUT_COORD_BITS-1:0] req_out_row,
   input  qstat_type                 qstat,
   output logic                      cmd_push,
   output cmd_type                   cmd_data
);

   localparam int SUM_BITS = CMD_CNT_BITS + 1;

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_type_ff;
   logic [SRC_COORD_BITS-1:0] s1_col_ff, s1_row_ff;
   logic [IN_PIX_BITS-1:0]    s1_pixel_ff;
   logic [OUT_COORD_BITS-1:0] s1_ocol_ff, s1_orow_ff;

   logic                      s2_valid_ff, s2_valid_in;
   logic                      s2_type_ff;
   logic [SRC_COORD_BITS-1:0] s2_col_ff, s2_row_ff;
   logic [IN_PIX_BITS-1:0]    s2_pixel_ff;
   logic [POS_BITS-1:0]       s2_gx_ff, s2_gy_ff;
   logic [POS_BITS-1:0]       gx_in, gy_in;

   logic                      accept;
   logic [SUM_BITS-1:0]       in_flight;
   logic [DIM_W_BITS-1:0]     w_used;
   logic [DIM_H_BITS-1:0]     h_used;
   logic [COL_BITS-1:0]       last_col, x0, x1;
   logic [ROW_BITS-1:0]       last_row, y0, y1;
   logic [INT_BITS-1:0]       xi, yi;
   logic                      write_ok;

   // Stall the port once the queue could not take every word in flight
   assign in_flight = SUM_BITS'(qstat.count) + SUM_BITS'(s1_valid_ff)
                    + SUM_BITS'(s2_valid_ff);
   assign full      = in_flight >= SUM_BITS'(CMD_DEPTH);
   assign accept    = push && !full;

   assign s1_valid_in = accept;
   assign s2_valid_in = s1_valid_ff;

   // Scale output coordinates by the step registers
   assign gx_in = POS_BITS'(s1_ocol_ff) * POS_BITS'(cfg.col_step);
   assign gy_in = POS_BITS'(s1_orow_ff) * POS_BITS'(cfg.row_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Capture the word and the products
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_type_ff  <= req_type;
         s1_col_ff   <= req_src_col;
         s1_row_ff   <= req_src_row;
         s1_pixel_ff <= req_pixel_in;
         s1_ocol_ff  <= req_out_col;
         s1_orow_ff  <= req_out_row;
      end
      if (s1_valid_ff) begin
         s2_type_ff  <= s1_type_ff;
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;
         s2_pixel_ff <= s1_pixel_ff;
         s2_gx_ff    <= gx_in;
         s2_gy_ff    <= gy_in;
      end
   end

   // Size in use: zero reads as one, oversize reads as the store size
   always_comb begin
      if (cfg.src_width == '0) begin
         w_used = DIM_W_BITS'(1);
      end else if (32'(cfg.src_width) > 32'(MAX_SRC_WIDTH)) begin
         w_used = DIM_W_BITS'(MAX_SRC_WIDTH);
      end else begin
         w_used = DIM_W_BITS'(cfg.src_width);
      end
      if (cfg.src_height == '0) begin
         h_used = DIM_H_BITS'(1);
      end else if (32'(cfg.src_height) > 32'(MAX_SRC_HEIGHT)) begin
         h_used = DIM_H_BITS'(MAX_SRC_HEIGHT);
      end else begin
         h_used = DIM_H_BITS'(cfg.src_height);
      end
   end

   assign last_col = COL_BITS'(w_used - DIM_W_BITS'(1));
   assign last_row = ROW_BITS'(h_used - DIM_H_BITS'(1));

   // Clamp the neighbours to the last column and row in use
   assign xi = s2_gx_ff[POS_BITS-1:FRAC_BITS];
   assign yi = s2_gy_ff[POS_BITS-1:FRAC_BITS];
   assign x0 = (xi >= INT_BITS'(last_col)) ? last_col : xi[COL_BITS-1:0];
   assign y0 = (yi >= INT_BITS'(last_row)) ? last_row : yi[ROW_BITS-1:0];
   assign x1 = (x0 == last_col) ? last_col : x0 + COL_BITS'(1);
   assign y1 = (y0 == last_row) ? last_row : y0 + ROW_BITS'(1);

   // Drop writes that fall outside the store
   assign write_ok = (32'(s2_col_ff) < 32'(MAX_SRC_WIDTH))
                  && (32'(s2_row_ff) < 32'(MAX_SRC_HEIGHT));

   // Classify and build the command
   always_comb begin
      cmd_push       = s2_valid_ff && (s2_type_ff == REQ_READ || write_ok);
      cmd_data.fx    = s2_gx_ff[FRAC_BITS-1:0];
      cmd_data.fy    = s2_gy_ff[FRAC_BITS-1:0];
      cmd_data.pixel = PIXEL_BITS'(s2_pixel_ff);
      if (s2_type_ff == REQ_WRITE) begin
         cmd_data.op = OP_WRITE;
         cmd_data.x0 = COL_BITS'(s2_col_ff);
         cmd_data.x1 = COL_BITS'(s2_col_ff);
         cmd_data.y0 = ROW_BITS'(s2_row_ff);
         cmd_data.y1 = ROW_BITS'(s2_row_ff);
      end else begin
         cmd_data.op = (cfg.interp_mode == MODE_BILINEAR) ? OP_BLEND : OP_NEAREST;
         cmd_data.x0 = x0;
         cmd_data.x1 = x1;
         cmd_data.y0 = y0;
         cmd_data.y1 = y1;
      end
   end

endmodule

FILE: rtl/bisc_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on bisc_pkg for the command type and depth.
module bisc_cmd_queue import bisc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   push_data,
   input  logic      pop,
   output cmd_type   head,
   output qstat_type qstat
);

   cmd_type                 entry_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_BITS-1:0] count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CMD_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + CMD_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_BITS'(push) - CMD_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the words
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head        = entry_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.count = count_ff;

endmodule

FILE: rtl/bisc_back.sv
// Back end: frame store, access sequencer, blend stages and result queue.
// Depends on bisc_pkg for the command type, sizes and the blend function.
module bisc_back import bisc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               head,
   input  qstat_type             qstat,
   output logic                  cmd_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [PIXEL_BITS-1:0] rsp_pixel
);

   // Neighbour order of a blend: upper left, upper right, lower left,
   // lower right
   localparam logic [1:0] STEP_P00 = 2'd0;
   localparam logic [1:0] STEP_P01 = 2'd1;
   localparam logic [1:0] STEP_P10 = 2'd2;
   localparam logic [1:0] STEP_P11 = 2'd3;

   localparam int CREDIT_BITS = OUT_CNT_BITS + 1;

   logic [PIXEL_BITS-1:0]   frame_store_ff [STORE_DEPTH];

   logic                    cur_valid_ff, cur_valid_in;
   cmd_type                 cur_ff;
   logic [1:0]              step_ff, step_in;
   logic                    cur_last, take, reserve, credit_ok;

   logic                    mem_we, mem_re;
   logic [ADDR_BITS-1:0]    mem_addr;
   logic [COL_BITS-1:0]     acc_col;
   logic [ROW_BITS-1:0]     acc_row;

   logic                    rd_valid_ff;
   logic                    rd_blend_ff;
   logic [1:0]              rd_step_ff;
   logic [FRAC_BITS-1:0]    rd_fx_ff, rd_fy_ff;
   logic [PIXEL_BITS-1:0]   rd_data_ff;

   logic [PIXEL_BITS-1:0]   hold_ff, hold_in;
   logic [PIXEL_BITS-1:0]   top_ff, top_in;
   logic                    fin_valid_ff, fin_valid_in;
   logic [PIXEL_BITS-1:0]   fin_top_ff, fin_top_in;
   logic [PIXEL_BITS-1:0]   fin_bot_ff, fin_bot_in;
   logic [FRAC_BITS-1:0]    fin_fy_ff, fin_fy_in;
   logic [PIXEL_BITS-1:0]   result;

   logic [PIXEL_BITS-1:0]   out_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0] out_wr_ff, out_wr_in;
   logic [OUT_PTR_BITS-1:0] out_rd_ff, out_rd_in;
   logic [OUT_CNT_BITS-1:0] out_count_ff, out_count_in;
   logic [OUT_CNT_BITS-1:0] pend_ff, pend_in;
   logic                    out_push, out_pop;

   // Reserve a result slot for every read taken on
   assign credit_ok = (CREDIT_BITS'(out_count_ff) + CREDIT_BITS'(pend_ff))
                    < CREDIT_BITS'(OUT_DEPTH);
   assign cur_last  = (cur_ff.op != OP_BLEND) || (step_ff == STEP_P11);
   assign take      = (!cur_valid_ff || cur_last) && !qstat.empty
                   && (head.op == OP_WRITE || credit_ok);
   assign reserve   = take && (head.op != OP_WRITE);
   assign cmd_pop   = take;

   // Sequence one access per cycle while a command is held
   always_comb begin
      if (take) begin
         cur_valid_in = 1'b1;
         step_in      = STEP_P00;
      end else begin
         cur_valid_in = cur_valid_ff && !cur_last;
         step_in      = step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= STEP_P00;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= head;
      end
   end

   // Address the neighbour of this step
   assign acc_col  = step_ff[0] ? cur_ff.x1 : cur_ff.x0;
   assign acc_row  = step_ff[1] ? cur_ff.y1 : cur_ff.y0;
   assign mem_addr = ADDR_BITS'(acc_row) * ADDR_BITS'(MAX_SRC_WIDTH)
                   + ADDR_BITS'(acc_col);
   assign mem_we   = cur_valid_ff && (cur_ff.op == OP_WRITE);
   assign mem_re   = cur_valid_ff && (cur_ff.op != OP_WRITE);

   // Single-port frame store with registered read data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store_ff[mem_addr] <= cur_ff.pixel;
      end
      if (mem_re) begin
         rd_data_ff <= frame_store_ff[mem_addr];
      end
   end

   // Carry the step tag alongside the read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= mem_re;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_blend_ff <= (cur_ff.op == OP_BLEND);
         rd_step_ff  <= step_ff;
         rd_fx_ff    <= cur_ff.fx;
         rd_fy_ff    <= cur_ff.fy;
      end
   end

   // Gather neighbours and blend each row pair horizontally
   always_comb begin
      hold_in      = hold_ff;
      top_in       = top_ff;
      fin_valid_in = 1'b0;
      fin_top_in   = fin_top_ff;
      fin_bot_in   = fin_bot_ff;
      fin_fy_in    = fin_fy_ff;
      if (rd_valid_ff) begin
         if (!rd_blend_ff) begin
            fin_valid_in = 1'b1;
            fin_top_in   = rd_data_ff;
            fin_bot_in   = rd_data_ff;
            fin_fy_in    = '0;
         end else begin
            case (rd_step_ff) inside
               STEP_P00, STEP_P10: begin
                  hold_in = rd_data_ff;
               end
               STEP_P01: begin
                  top_in = lerp(hold_ff, rd_data_ff, rd_fx_ff);
               end
               default: begin
                  fin_valid_in = 1'b1;
                  fin_top_in   = top_ff;
                  fin_bot_in   = lerp(hold_ff, rd_data_ff, rd_fx_ff);
                  fin_fy_in    = rd_fy_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff    <= hold_in;
      top_ff     <= top_in;
      fin_top_ff <= fin_top_in;
      fin_bot_ff <= fin_bot_in;
      fin_fy_ff  <= fin_fy_in;
   end

   // Vertical blend into the result queue
   assign result   = lerp(fin_top_ff, fin_bot_ff, fin_fy_ff);
   assign out_push = fin_valid_ff;
   assign out_pop  = rsp_pop && !rsp_empty;

   always_comb begin
      out_wr_in    = out_push ? out_wr_ff + OUT_PTR_BITS'(1) : out_wr_ff;
      out_rd_in    = out_pop ? out_rd_ff + OUT_PTR_BITS'(1) : out_rd_ff;
      out_count_in = out_count_ff + OUT_CNT_BITS'(out_push)
                   - OUT_CNT_BITS'(out_pop);
      pend_in      = pend_ff + OUT_CNT_BITS'(reserve) - OUT_CNT_BITS'(out_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
         pend_ff      <= '0;
      end else begin
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= result;
      end
   end

   assign rsp_empty = (out_count_ff == '0);
   assign rsp_pixel = out_mem_ff[out_rd_ff];

endmodule

FILE: rtl/bilinear_image_scaler_unit.sv
// Channel  Handshake            Word
// req      push / full          req_type, src col/row, pixel_in, out col/row
// rsp      empty / pop          rsp_pixel_out
// csr      csr_wr_en            csr_index, csr_wdata (no wait, no read-back)
//
// The front end takes a word every cycle while the command queue has room.
// The back end owns the single frame store port: a write or a nearest read
// occupies it for a single access, a bilinear read for one access per
// neighbour; the next command is taken only during the last access.
// Reset is synchronous and clears control state only; the frame store
// holds nothing valid until written. A withheld pop stalls the back end once
// the result queue and the results in flight fill it.
module bilinear_image_scaler_unit import bisc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_type,
   input  logic [SRC_COORD_BITS-1:0] req_src_col,
   input  logic [SRC_COORD_BITS-1:0] req_src_row,
   input  logic [IN_PIX_BITS-1:0]    req_pixel_in,
   input  logic [OUT_COORD_BITS-1:0] req_out_col,
   input  logic [OUT_COORD_BITS-1:0] req_out_row,
   output logic                      empty,
   input  logic                      pop,
   output logic [OUT_PIX_BITS-1:0]   rsp_pixel_out,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type               cfg_ff, cfg_in;
   cmd_type               cmd_data, cmd_head;
   logic                  cmd_push, cmd_pop;
   qstat_type             qstat;
   logic [PIXEL_BITS-1:0] rsp_pixel;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:   cfg_in.src_width   = csr_wdata[SIZE_BITS-1:0];
            CSR_SRC_HEIGHT:  cfg_in.src_height  = csr_wdata[SIZE_BITS-1:0];
            CSR_COL_STEP:    cfg_in.col_step    = csr_wdata[STEP_BITS-1:0];
            CSR_ROW_STEP:    cfg_in.row_step    = csr_wdata[STEP_BITS-1:0];
            CSR_INTERP_MODE: cfg_in.interp_mode = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width   <= SIZE_RESET;
         cfg_ff.src_height  <= SIZE_RESET;
         cfg_ff.col_step    <= STEP_RESET;
         cfg_ff.row_step    <= STEP_RESET;
         cfg_ff.interp_mode <= MODE_BILINEAR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bisc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .push         (push),
      .full         (full),
      .req_type     (req_type),
      .req_src_col  (req_src_col),
      .req_src_row  (req_src_row),
      .req_pixel_in (req_pixel_in),
      .req_out_col  (req_out_col),
      .req_out_row  (req_out_row),
      .qstat        (qstat),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_data)
   );

   bisc_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .qstat     (qstat)
   );

   bisc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (cmd_head),
      .qstat     (qstat),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_pixel (rsp_pixel)
   );

   assign rsp_pixel_out = OUT_PIX_BITS'(rsp_pixel);

endmodule

FILE: rtl/bisc_port_checker.sv
// Port-level checks on the image scaler, bound to its top level.
// Depends on bisc_pkg and the assertion macros header.
`include "bilinear_image_scaler_unit_defines.svh"

module bisc_port_checker import bisc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    push,
   input logic                    full,
   input logic                    empty,
   input logic                    pop,
   input logic [OUT_PIX_BITS-1:0] rsp_pixel_out
);

   // Queues come out of reset drained
   `BISC_ASSERT_RESET(a_reset_empty, empty, "result queue not empty after reset")
   `BISC_ASSERT_RESET(a_reset_not_full, !full, "input stalled after reset")

   // Backpressure only grows by an accepted word
   `BISC_ASSERT_NOW(a_full_needs_push, $rose(full), $past(push && !full), "full rose without a word")

   // Results only leave by a pop
   `BISC_ASSERT_NOW(a_empty_needs_pop, $rose(empty), $past(pop), "result lost without pop")

   // Hold a waiting result
   `BISC_ASSERT_NEXT(a_head_holds, !empty && !pop, !empty && $stable(rsp_pixel_out), "result changed while waiting")

endmodule

bind bilinear_image_scaler_unit bisc_port_checker u_port_checker (
   .clock         (clock),
   .reset         (reset),
   .push          (push),
   .full          (full),
   .empty         (empty),
   .pop           (pop),
   .rsp_pixel_out (rsp_pixel_out)
);
